@@ hw/rtl/lprh_pkg.sv @@
// Package for the linear-probing reverse hash block: sizes, codes and state type.
// No dependencies; every other file imports it.
package lprh_pkg;
	localparam int TableDepth = 1024;
	localparam int SlotW = $clog2(TableDepth);
	localparam int KeyW = 32;
	localparam int SizeW = SlotW + 1;
	localparam int HashShift = 6;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_HASH, S_RD, S_CHK, S_KRD, S_KCHK,
		S_DSCAN, S_DRD, S_DCHK, S_DKRD, S_DHASH, S_DONE
	} state_t;
endpackage

@@ hw/rtl/lprh_mod.sv @@
// Sequential modulo unit: remainder of a key by the table size, one bit per cycle.
// Depends on lprh_pkg.
module lprh_mod import lprh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [KeyW-1:0] dividend,
	input logic [SizeW-1:0] divisor,
	output logic done,
	output logic [SlotW-1:0] remainder
);
	logic [KeyW-1:0] num_q;
	logic [SizeW:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [SizeW:0] shifted;

	assign shifted = {rem_q[SizeW-1:0], num_q[KeyW-1]};
	assign remainder = rem_q[SlotW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(KeyW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[KeyW-2:0], 1'b0};
			if (shifted >= {1'b0, divisor}) rem_q <= shifted - {1'b0, divisor};
			else rem_q <= shifted;
		end
	end
endmodule

@@ hw/rtl/linear_probe_reverse_hash.sv @@
// Linear-probing reverse hash table with backward-shift deletion (top level).
// The key is hashed first by the modulo unit, then slots are probed in turn, with an
// extra key read where a lookup compares a stored key; a delete also rehashes each key
// that it scans after the hole. Bad indexes and the unused opcode answer without the hash.
// One item at a time; the shared bit-serial modulo unit and the one-read, one-write slot
// memory set the rate. After reset a clearing pass zeroes every slot entry; no beat is
// taken meanwhile, while table_size writes are accepted. Uses lprh_pkg, lprh_mod.
module linear_probe_reverse_hash import lprh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [10:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [31:0] object_key,
	input logic [9:0] entry_index,
	output logic out_valid,
	input logic out_ready,
	output logic [9:0] found_index,
	output logic [1:0] status
);
	state_t state_q, state_d;
	logic [10:0] table_size_q;
	logic [SizeW-1:0] size_q;
	logic [SlotW-1:0] clr_q;
	logic [1:0] op_q;
	logic [KeyW-1:0] key_q;
	logic [SlotW-1:0] idx_q;
	logic [SlotW-1:0] p_q, hole_q;
	logic [SizeW-1:0] n_q;
	logic [SlotW-1:0] v_q;

	// Slot and key memories, read data registered.
	logic [SlotW-1:0] slot_mem [TableDepth];
	logic [KeyW-1:0] key_mem [TableDepth];
	logic [SlotW-1:0] slot_rd;
	logic [KeyW-1:0] key_rd;
	logic slot_we;
	logic [SlotW-1:0] slot_wa, slot_wd, slot_ra, key_ra;
	logic key_we;

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd <= slot_mem[slot_ra];
	end
	always_ff @(posedge clk) begin
		if (key_we) key_mem[idx_q] <= key_q;
		key_rd <= key_mem[key_ra];
	end

	// Effective size: the register clamped to [2, depth].
	logic [SizeW-1:0] eff_size;
	always_comb begin
		if (table_size_q < 11'd2) eff_size = SizeW'(2);
		else if (table_size_q > 11'(TableDepth)) eff_size = SizeW'(TableDepth);
		else eff_size = SizeW'(table_size_q);
	end

	// Shared modulo unit for both the probe key and rehashed keys.
	logic mod_start, mod_done;
	logic [KeyW-1:0] mod_in;
	logic [SlotW-1:0] mod_rem;
	lprh_mod u_mod (.clk, .arst_n, .start(mod_start), .dividend(mod_in),
		.divisor(size_q), .done(mod_done), .remainder(mod_rem));

	function automatic logic [SlotW-1:0] nxt(input logic [SlotW-1:0] p,
			input logic [SizeW-1:0] s);
		logic [SizeW-1:0] q;
		q = {1'b0, p} + SizeW'(1);
		return (q >= s) ? '0 : q[SlotW-1:0];
	endfunction

	logic [SlotW-1:0] p_nx;
	logic [SizeW-1:0] n_nx;
	logic key_eq, shift_ok, fin;
	logic [1:0] st_d;
	logic [SlotW-1:0] fi_d;
	assign p_nx = nxt(p_q, size_q);
	assign n_nx = n_q + SizeW'(1);
	assign key_eq = (key_rd == key_q);
	// Entry at p_q with home mod_rem may move into the hole.
	assign shift_ok = (p_q < hole_q) ? ((p_q < mod_rem) && (mod_rem <= hole_q))
		: ((p_q < mod_rem) || (mod_rem <= hole_q));

	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		st_d = ST_OK;
		fi_d = '0;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_HASH;
			S_CLEAR: if (&clr_q) state_d = S_IDLE;
			S_HASH: begin
				if (op_q == OP_NONE) begin
					fin = 1'b1;
				end else if (op_q != OP_LOOKUP &&
						(idx_q == '0 || {1'b0, idx_q} >= size_q)) begin
					fin = 1'b1;
					st_d = ST_BAD_INDEX;
				end else if (mod_done) begin
					state_d = S_RD;
				end
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (op_q == OP_LOOKUP) begin
					if (slot_rd == '0) begin
						fin = 1'b1;
						st_d = ST_NOT_FOUND;
					end else state_d = S_KRD;
				end else if (op_q == OP_INSERT) begin
					if (slot_rd == '0) fin = 1'b1;
					else if (n_nx >= size_q) begin
						fin = 1'b1;
						st_d = ST_NOT_FOUND;
					end else state_d = S_RD;
				end else begin
					if (slot_rd == idx_q) state_d = S_DSCAN;
					else if (n_nx >= size_q) begin
						fin = 1'b1;
						st_d = ST_NOT_FOUND;
					end else state_d = S_RD;
				end
			end
			S_KRD: state_d = S_KCHK;
			S_KCHK: begin
				if (key_eq) begin
					fin = 1'b1;
					fi_d = v_q;
				end else if (n_nx >= size_q) begin
					fin = 1'b1;
					st_d = ST_NOT_FOUND;
				end else state_d = S_RD;
			end
			S_DSCAN: begin
				if (p_nx == hole_q || n_nx >= size_q) fin = 1'b1;
				else state_d = S_DRD;
			end
			S_DRD: state_d = S_DCHK;
			S_DCHK: begin
				if (slot_rd == '0) fin = 1'b1;
				else state_d = S_DKRD;
			end
			S_DKRD: state_d = S_DHASH;
			S_DHASH: begin
				if (mod_done) begin
					if (shift_ok) state_d = S_DSCAN;
					else if (p_nx == hole_q || n_nx >= size_q) fin = 1'b1;
					else state_d = S_DRD;
				end
			end
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (fin) state_d = S_DONE;
	end

	// Memory and modulo-unit controls.
	always_comb begin
		slot_we = 1'b0;
		slot_wa = hole_q;
		slot_wd = '0;
		key_we = 1'b0;
		slot_ra = p_q;
		key_ra = slot_rd;
		mod_start = 1'b0;
		mod_in = key_q >> HashShift;
		unique case (state_q)
			S_CLEAR: begin
				slot_we = 1'b1;
				slot_wa = clr_q;
			end
			S_HASH: mod_start = 1'b0;
			S_CHK: begin
				if (op_q == OP_INSERT && slot_rd == '0) begin
					slot_we = 1'b1;
					slot_wa = p_q;
					slot_wd = idx_q;
					key_we = 1'b1;
				end
			end
			// Keep the key of the slot under test on the read port for the compare.
			S_KRD: key_ra = v_q;
			S_DSCAN: slot_ra = p_nx;
			S_DCHK: begin
				if (slot_rd == '0) slot_we = 1'b1;
			end
			S_DKRD: begin
				mod_start = 1'b1;
				mod_in = key_rd >> HashShift;
			end
			S_DHASH: begin
				if (mod_done && shift_ok) begin
					slot_we = 1'b1;
					slot_wd = v_q;
				end else if (mod_done && (p_nx == hole_q || n_nx >= size_q)) begin
					slot_we = 1'b1;
				end
			end
			default: ;
		endcase
		if (state_q == S_DSCAN && (p_nx == hole_q || n_nx >= size_q)) slot_we = 1'b1;
		if (state_q == S_IDLE && in_valid) mod_start = 1'b1;
		if (state_q == S_IDLE) mod_in = object_key >> HashShift;
		if (state_q == S_DHASH && mod_done && !shift_ok) slot_ra = p_nx;
		if (state_q == S_CHK || state_q == S_KCHK) slot_ra = p_nx;
		if (state_q == S_HASH) slot_ra = mod_rem;
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			table_size_q <= 11'(TableDepth);
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + SlotW'(1);
			if (cfg_we) table_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= opcode;
			key_q <= object_key;
			idx_q <= entry_index;
			size_q <= eff_size;
		end
		if (fin) begin
			found_index <= fi_d;
			status <= st_d;
		end
		unique case (state_q)
			S_HASH: begin
				p_q <= mod_rem;
				n_q <= '0;
			end
			S_CHK: begin
				v_q <= slot_rd;
				if (op_q == OP_DELETE && slot_rd == idx_q) begin
					hole_q <= p_q;
					n_q <= '0;
				end else if (op_q != OP_LOOKUP) begin
					p_q <= p_nx;
					n_q <= n_nx;
				end
			end
			S_KCHK: begin
				p_q <= p_nx;
				n_q <= n_nx;
			end
			S_DSCAN: begin
				p_q <= p_nx;
				n_q <= n_nx;
			end
			S_DCHK: v_q <= slot_rd;
			S_DHASH: begin
				if (mod_done) begin
					if (shift_ok) hole_q <= p_q;
					else begin
						p_q <= p_nx;
						n_q <= n_nx;
					end
				end
			end
			default: ;
		endcase
	end

	// The probe pointer never leaves the table in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> ({1'b0, p_q} < size_q))
		else $error("probe pointer beyond table size");
	// A result is held until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("result dropped");
	// No item is taken during the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("ready during clear");
endmodule

@@ dv/tb_linear_probe_reverse_hash.sv @@
// Testbench for linear_probe_reverse_hash: directed table, then random traffic.
// Results are checked against a behavioral hash table kept inside the testbench.
// Depends on lprh_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_linear_probe_reverse_hash import lprh_pkg::*; ();

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [10:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [1:0] opcode;
	logic [31:0] object_key;
	logic [9:0] entry_index;
	logic out_valid;
	logic out_ready;
	logic [9:0] found_index;
	logic [1:0] status;

	linear_probe_reverse_hash dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.object_key(object_key),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found_index(found_index),
		.status(status)
	);

	// One expected result beat. The flag marks rows whose values were typed in by hand,
	// which are compared with both the hand values and the table model.
	typedef struct {
		logic [9:0] index;
		status_t st;
	} answer_t;

	typedef struct {
		op_t op;
		logic [31:0] key;
		logic [9:0] idx;
		logic fixed;
		logic [9:0] want_index;
		status_t want_st;
	} stim_t;

	// Behavioral copy of the hash table state.
	logic [9:0] slots [TableDepth];
	logic [31:0] keys [TableDepth];
	logic [10:0] size_reg;

	answer_t pending_answers[$];
	int errors = 0;
	bit calm = 0;        // no random idling in the last part of the run
	bit hold_off = 0;    // receiver holds off for a long stretch

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic int eff_size();
		int s;
		s = size_reg;
		if (s < 2) s = 2;
		if (s > TableDepth) s = TableDepth;
		return s;
	endfunction

	function automatic int home_slot(logic [31:0] key, int size);
		return int'((key >> HashShift) % size);
	endfunction

	// Applies one operation to the table model and returns the result it produces.
	function automatic answer_t apply_hash_op(op_t op, logic [31:0] key, logic [9:0] idx);
		answer_t r;
		int size, p, n, hole, d, steps, t;
		logic [9:0] v;
		bit hit, move;
		size = eff_size();
		r.index = '0;
		r.st = ST_OK;
		p = home_slot(key, size);
		if (op == OP_LOOKUP) begin
			r.st = ST_NOT_FOUND;
			for (n = 0; n < size; n++) begin
				v = slots[p];
				if (v == 0) break;
				if (keys[v] == key) begin
					r.index = v;
					r.st = ST_OK;
					break;
				end
				p = (p + 1 >= size) ? 0 : p + 1;
			end
		end else if (op == OP_INSERT || op == OP_DELETE) begin
			if (idx == 0 || idx >= size) begin
				r.st = ST_BAD_INDEX;
			end else if (op == OP_INSERT) begin
				r.st = ST_NOT_FOUND;
				for (n = 0; n < size; n++) begin
					if (slots[p] == 0) begin
						keys[idx] = key;
						slots[p] = idx;
						r.st = ST_OK;
						break;
					end
					p = (p + 1 >= size) ? 0 : p + 1;
				end
			end else begin
				hit = 0;
				for (n = 0; n < size; n++) begin
					if (slots[p] == idx) begin
						hit = 1;
						break;
					end
					p = (p + 1 >= size) ? 0 : p + 1;
				end
				if (!hit) begin
					r.st = ST_NOT_FOUND;
				end else begin
					// Backward shift: pull later members of the clump into the hole
					// when their home slot does not lie between the hole and them.
					hole = p;
					d = p;
					steps = 0;
					forever begin
						v = 0;
						forever begin
							d = (d + 1 >= size) ? 0 : d + 1;
							steps++;
							if (d == hole || steps >= size) begin
								v = 0;
								break;
							end
							v = slots[d];
							if (v == 0) break;
							t = home_slot(keys[v], size);
							move = (d < hole) ? ((d < t) && (t <= hole))
							                  : ((d < t) || (t <= hole));
							if (move) break;
						end
						slots[hole] = v;
						if (v == 0) break;
						hole = d;
					end
				end
			end
		end
		return r;
	endfunction

	// Sender: holds valid and payload steady until the beat is taken. Valid drops
	// only for an idle gap; otherwise the next beat follows straight away.
	task automatic send_beat(input stim_t s);
		answer_t a;
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= s.op;
		object_key <= s.key;
		entry_index <= s.idx;
		do @(posedge clk); while (!in_ready);
		a = apply_hash_op(s.op, s.key, s.idx);
		if (s.fixed && (a.index != s.want_index || a.st != s.want_st))
			report($sformatf("table model disagrees with hand value op %0d", s.op));
		pending_answers.push_back(a);
	endtask

	// Writes the size register once nothing is in flight.
	task automatic write_size(input logic [10:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_answers.size() == 0);
		// A result may just have left while the block is still finishing up.
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = value;
	endtask

	function automatic stim_t mk(op_t op, logic [31:0] key, logic [9:0] idx);
		stim_t s;
		s.op = op;
		s.key = key;
		s.idx = idx;
		s.fixed = 0;
		s.want_index = 0;
		s.want_st = ST_OK;
		return s;
	endfunction

	function automatic stim_t mkf(op_t op, logic [31:0] key, logic [9:0] idx,
			logic [9:0] wi, status_t ws);
		stim_t s;
		s = mk(op, key, idx);
		s.fixed = 1;
		s.want_index = wi;
		s.want_st = ws;
		return s;
	endfunction

	// Random operation on a small key pool so that clumps form and lookups hit.
	function automatic stim_t rand_item(int size);
		stim_t s;
		int r;
		logic [31:0] key;
		r = $urandom_range(0, 99);
		if (r < 80)
			key = ($urandom_range(0, 2 * size) << HashShift) | $urandom_range(0, 63);
		else
			key = $urandom;
		if (key == 0) key = 1;
		s = mk(OP_LOOKUP, key, 10'($urandom_range(1, size - 1)));
		r = $urandom_range(0, 99);
		if (r < 35) s.op = OP_INSERT;
		else if (r < 60) s.op = OP_DELETE;
		else if (r < 97) s.op = OP_LOOKUP;
		else s.op = OP_NONE;
		if ($urandom_range(0, 19) == 0) s.idx = 10'($urandom);
		return s;
	endfunction

	// Receiver: random stall bursts, plus one long hold-off to fill the block.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				gap = $urandom_range(1, 11);
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Checker: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				a = pending_answers.pop_front();
				if (found_index !== a.index)
					report($sformatf("found_index %0d, wanted %0d", found_index, a.index));
				if (status !== a.st)
					report($sformatf("status %0d, wanted %0d", status, a.st));
			end
		end
	end

	initial begin
		stim_t dir[$];
		int sizes[6];
		int ph, k, size, limit;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = OP_LOOKUP;
		object_key = '0;
		entry_index = '0;
		for (k = 0; k < TableDepth; k++) begin
			slots[k] = '0;
			keys[k] = '0;
		end
		size_reg = 11'd1024;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at full size. Keys 64 and 64+1024*64 share home slot 1.
		dir.push_back(mkf(OP_LOOKUP, 32'hFFFF_FFFF, 10'd0, 10'd0, ST_NOT_FOUND));
		dir.push_back(mkf(OP_INSERT, 32'd64, 10'd0, 10'd0, ST_BAD_INDEX));
		dir.push_back(mkf(OP_DELETE, 32'd64, 10'd0, 10'd0, ST_BAD_INDEX));
		dir.push_back(mkf(OP_NONE, 32'd1, 10'd5, 10'd0, ST_OK));
		dir.push_back(mkf(OP_INSERT, 32'd64, 10'd1023, 10'd0, ST_OK));
		dir.push_back(mkf(OP_LOOKUP, 32'd64, 10'd0, 10'd1023, ST_OK));
		dir.push_back(mkf(OP_INSERT, 32'd65600, 10'd7, 10'd0, ST_OK));
		dir.push_back(mkf(OP_INSERT, 32'd128, 10'd9, 10'd0, ST_OK));
		dir.push_back(mkf(OP_INSERT, 32'hFFFF_FFFF, 10'd1, 10'd0, ST_OK));
		dir.push_back(mkf(OP_INSERT, 32'd64, 10'd3, 10'd0, ST_OK));
		dir.push_back(mk(OP_LOOKUP, 32'd65600, 10'h3FF));
		dir.push_back(mkf(OP_DELETE, 32'd64, 10'd1023, 10'd0, ST_OK));
		dir.push_back(mk(OP_LOOKUP, 32'd128, 10'd0));
		dir.push_back(mk(OP_LOOKUP, 32'd65600, 10'd0));
		dir.push_back(mkf(OP_DELETE, 32'd64, 10'd500, 10'd0, ST_NOT_FOUND));
		dir.push_back(mkf(OP_LOOKUP, 32'hFFFF_FFFF, 10'd0, 10'd1, ST_OK));
		dir.push_back(mk(OP_LOOKUP, 32'hAAAA_5555, 10'h155));
		dir.push_back(mk(OP_DELETE, 32'h5555_AAAA, 10'd7));
		dir.push_back(mk(OP_LOOKUP, 32'd64, 10'h2AA));
		foreach (dir[k]) send_beat(dir[k]);

		// Size 2 and below: full-table insert, delete with no empty slot left.
		write_size(11'd0);
		dir.delete();
		dir.push_back(mkf(OP_INSERT, 32'd64, 10'd2, 10'd0, ST_BAD_INDEX));
		dir.push_back(mkf(OP_INSERT, 32'd64, 10'd1, 10'd0, ST_OK));
		dir.push_back(mkf(OP_LOOKUP, 32'd128, 10'd0, 10'd0, ST_NOT_FOUND));
		dir.push_back(mk(OP_INSERT, 32'd128, 10'd1));
		dir.push_back(mkf(OP_INSERT, 32'd192, 10'd1, 10'd0, ST_NOT_FOUND));
		dir.push_back(mk(OP_LOOKUP, 32'd5, 10'd0));
		dir.push_back(mk(OP_DELETE, 32'd64, 10'd1));
		dir.push_back(mk(OP_DELETE, 32'd64, 10'd1));
		dir.push_back(mk(OP_DELETE, 32'd64, 10'd1));
		foreach (dir[k]) send_beat(dir[k]);

		// Random phases over several sizes, the extremes among them. Shrinking leaves
		// stale slots, which the model keeps too.
		sizes = '{2047, 7, 1, 64, 1024, 13};
		for (ph = 0; ph < 6; ph++) begin
			write_size(11'(sizes[ph]));
			size = eff_size();
			limit = (ph == 5) ? 600 : 200;
			for (k = 0; k < limit; k++) begin
				if (ph == 4 && k == 50) hold_off = 1;
				if (ph == 5 && k == 400) calm = 1;
				send_beat(rand_item(size));
			end
		end
		in_valid <= 1'b0;

		wait (pending_answers.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/lprh_pkg.sv
hw/rtl/lprh_mod.sv
hw/rtl/linear_probe_reverse_hash.sv
dv/tb_linear_probe_reverse_hash.sv
